/* src/mmpp_pkg.sv */
// shared types and constants for the min/max peak pyramid
`default_nettype none
package mmpp_pkg;

	localparam int CFG_W  = 16;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	localparam logic [0:0] REG_BASE = 1'b0;
	localparam logic [0:0] REG_MINP = 1'b1;

	localparam logic [CFG_W-1:0] BASE_RST = 16'd256;
	localparam logic [CFG_W-1:0] MINP_RST = 16'd2;

	localparam logic KIND_PEAK    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic [CFG_W-1:0] base;
		logic [CFG_W-1:0] min_peaks;
	} cfg_t;

endpackage
`default_nettype wire

/* src/mmpp_regs.sv */
// apb configuration registers for the min/max peak pyramid
`default_nettype none
module mmpp_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mmpp_pkg::ADDR_W-1:0]  paddr,
	input  logic [mmpp_pkg::DATA_W-1:0]  pwdata,
	output logic [mmpp_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output mmpp_pkg::cfg_t               cfg
);
	import mmpp_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base      <= BASE_RST;
			cfg_q.min_peaks <= MINP_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_BASE: cfg_q.base      <= pwdata[CFG_W-1:0];
				REG_MINP: cfg_q.min_peaks <= pwdata[CFG_W-1:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_BASE: prdata = DATA_W'(cfg_q.base);
			REG_MINP: prdata = DATA_W'(cfg_q.min_peaks);
			default:  prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

/* src/minmax_peak_pyramid.sv */
// top level of the streaming min/max peak pyramid
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+------------------------------------------
//   input     | in_valid / in_ready        | sample, last_sample
//   output    | out_valid / out_ready      | kind, level, peak_min, peak_max,
//             |                            | level_count, levels_clipped, last
//   config    | psel / penable / pwrite    | paddr, pwdata, prdata, pready
//
// a sample that closes no chunk is absorbed directly; a closed chunk emits its peaks one after another,
// all through the single shared min/max comparator
// a last sample then adds a scan of the pending levels that emits each peak it flushes,
// then level counting and the summary beat
// in_ready is low while a chunk peak, flush, level count or summary is in progress
// output beats wait in one output register; a stalled output holds the sequencer
// reset clears chunk, pending peaks and peak counters at once
`default_nettype none
module minmax_peak_pyramid #(
	parameter int MAX_LEVELS  = 16,
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                         last_sample,
	input  logic                         in_valid,
	output logic                         in_ready,
	output logic                         kind,
	output logic [3:0]                   level,
	output logic signed [15:0]           peak_min,
	output logic signed [15:0]           peak_max,
	output logic [4:0]                   level_count,
	output logic                         levels_clipped,
	output logic                         last,
	output logic                         out_valid,
	input  logic                         out_ready,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mmpp_pkg::ADDR_W-1:0]  paddr,
	input  logic [mmpp_pkg::DATA_W-1:0]  pwdata,
	output logic [mmpp_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import mmpp_pkg::*;

	localparam int LVL_W = $clog2(MAX_LEVELS);
	localparam int KW    = $clog2(MAX_LEVELS + 1);
	localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
	localparam logic [LVL_W-1:0] TOP = LVL_W'(MAX_LEVELS - 1);
	localparam logic signed [SAMPLE_BITS-1:0] SPOS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SNEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INSERT,
		ST_FLUSH,
		ST_COUNT,
		ST_SUMMARY
	} state_t;

	cfg_t cfg;

	mmpp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	state_t                         state_q;
	logic [CFG_W-1:0]               chunk_fill_q;
	logic signed [SAMPLE_BITS-1:0]  chunk_low_q;
	logic signed [SAMPLE_BITS-1:0]  chunk_high_q;
	logic [MAX_LEVELS-1:0]          pending_valid_q;
	logic signed [SAMPLE_BITS-1:0]  pend_lo_q [MAX_LEVELS];
	logic signed [SAMPLE_BITS-1:0]  pend_hi_q [MAX_LEVELS];
	logic [COUNT_BITS-1:0]          peaks_q   [MAX_LEVELS];
	logic [LVL_W-1:0]               cur_lvl_q;
	logic signed [SAMPLE_BITS-1:0]  cur_lo_q;
	logic signed [SAMPLE_BITS-1:0]  cur_hi_q;
	logic                           fin_q;
	logic [LVL_W-1:0]               scan_q;
	logic [KW-1:0]                  k_q;
	logic                           clip_q;

	logic                           out_valid_q;
	logic                           out_kind_q;
	logic [3:0]                     out_level_q;
	logic [SAMPLE_BITS-1:0]         out_min_q;
	logic [SAMPLE_BITS-1:0]         out_max_q;
	logic [4:0]                     out_count_q;
	logic                           out_clip_q;
	logic                           out_last_q;

	logic signed [SAMPLE_BITS-1:0]  a_lo, a_hi, b_lo, b_hi, mm_lo, mm_hi;
	logic [LVL_W-1:0]               rd_idx, pk_idx;
	logic [CFG_W:0]                 fill_inc;
	logic [CFG_W-1:0]               base_eff, thr;
	logic                           close;
	logic                           out_free;
	logic                           out_load;
	logic                           peaks_ge;
	logic                           pend_we;
	logic                           top_lvl;

	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign out_load = out_free && ((state_q == ST_INSERT) || (state_q == ST_SUMMARY));
	assign top_lvl  = (cur_lvl_q == TOP);

	assign rd_idx = (state_q == ST_FLUSH) ? scan_q : cur_lvl_q;
	assign pk_idx = (state_q == ST_COUNT) ? LVL_W'(k_q - KW'(1)) : cur_lvl_q;

	// shared min/max unit
	always_comb begin
		if (state_q == ST_IDLE) begin
			a_lo = chunk_low_q;
			a_hi = chunk_high_q;
			b_lo = sample;
			b_hi = sample;
		end else begin
			a_lo = cur_lo_q;
			a_hi = cur_hi_q;
			b_lo = pend_lo_q[rd_idx];
			b_hi = pend_hi_q[rd_idx];
		end
		mm_lo = (b_lo < a_lo) ? b_lo : a_lo;
		mm_hi = (b_hi > a_hi) ? b_hi : a_hi;
	end

	assign fill_inc = {1'b0, chunk_fill_q} + (CFG_W+1)'(1);
	assign base_eff = (cfg.base == '0) ? CFG_W'(1) : cfg.base;
	assign close    = (fill_inc >= {1'b0, base_eff}) || last_sample;
	assign thr      = (cfg.min_peaks < CFG_W'(2)) ? CFG_W'(2) : cfg.min_peaks;
	assign peaks_ge = CMP_W'(peaks_q[pk_idx]) >= CMP_W'(thr);
	assign pend_we  = (state_q == ST_INSERT) && out_free && !top_lvl
	                  && !pending_valid_q[cur_lvl_q];

	always_ff @(posedge clk) begin
		if (pend_we) begin
			pend_lo_q[cur_lvl_q] <= cur_lo_q;
			pend_hi_q[cur_lvl_q] <= cur_hi_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			chunk_fill_q    <= '0;
			chunk_low_q     <= SPOS;
			chunk_high_q    <= SNEG;
			pending_valid_q <= '0;
			peaks_q         <= '{default: '0};
			cur_lvl_q       <= '0;
			cur_lo_q        <= '0;
			cur_hi_q        <= '0;
			fin_q           <= 1'b0;
			scan_q          <= '0;
			k_q             <= KW'(1);
			clip_q          <= 1'b0;
			out_valid_q     <= 1'b0;
			out_kind_q      <= KIND_PEAK;
			out_level_q     <= '0;
			out_min_q       <= '0;
			out_max_q       <= '0;
			out_count_q     <= '0;
			out_clip_q      <= 1'b0;
			out_last_q      <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (close) begin
							cur_lvl_q    <= '0;
							cur_lo_q     <= mm_lo;
							cur_hi_q     <= mm_hi;
							fin_q        <= last_sample;
							scan_q       <= '0;
							chunk_fill_q <= '0;
							chunk_low_q  <= SPOS;
							chunk_high_q <= SNEG;
							state_q      <= ST_INSERT;
						end else begin
							chunk_fill_q <= fill_inc[CFG_W-1:0];
							chunk_low_q  <= mm_lo;
							chunk_high_q <= mm_hi;
						end
					end
				end
				ST_INSERT: begin
					if (out_free) begin
						out_kind_q  <= KIND_PEAK;
						out_level_q <= 4'(cur_lvl_q);
						out_min_q   <= cur_lo_q;
						out_max_q   <= cur_hi_q;
						out_count_q <= '0;
						out_clip_q  <= 1'b0;
						out_last_q  <= !fin_q && (top_lvl || !pending_valid_q[cur_lvl_q]);
						if (peaks_q[cur_lvl_q] != CMAX)
							peaks_q[cur_lvl_q] <= peaks_q[cur_lvl_q] + COUNT_BITS'(1);
						if (!top_lvl && pending_valid_q[cur_lvl_q]) begin
							cur_lo_q                   <= mm_lo;
							cur_hi_q                   <= mm_hi;
							pending_valid_q[cur_lvl_q] <= 1'b0;
							cur_lvl_q                  <= cur_lvl_q + LVL_W'(1);
						end else begin
							if (!top_lvl)
								pending_valid_q[cur_lvl_q] <= 1'b1;
							state_q <= fin_q ? ST_FLUSH : ST_IDLE;
						end
					end
				end
				ST_FLUSH: begin
					if (scan_q == TOP) begin
						k_q     <= KW'(1);
						clip_q  <= 1'b0;
						state_q <= ST_COUNT;
					end else if (pending_valid_q[scan_q]) begin
						pending_valid_q[scan_q] <= 1'b0;
						cur_lvl_q <= scan_q + LVL_W'(1);
						cur_lo_q  <= pend_lo_q[scan_q];
						cur_hi_q  <= pend_hi_q[scan_q];
						scan_q    <= scan_q + LVL_W'(1);
						state_q   <= ST_INSERT;
					end else begin
						scan_q <= scan_q + LVL_W'(1);
					end
				end
				ST_COUNT: begin
					if (peaks_ge) begin
						if (k_q == KW'(MAX_LEVELS)) begin
							clip_q  <= 1'b1;
							state_q <= ST_SUMMARY;
						end else begin
							k_q <= k_q + KW'(1);
						end
					end else begin
						state_q <= ST_SUMMARY;
					end
				end
				ST_SUMMARY: begin
					if (out_free) begin
						out_kind_q  <= KIND_SUMMARY;
						out_level_q <= '0;
						out_min_q   <= '0;
						out_max_q   <= '0;
						out_count_q <= 5'(k_q);
						out_clip_q  <= clip_q;
						out_last_q  <= 1'b1;
						peaks_q     <= '{default: '0};
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = out_kind_q;
	assign level          = out_level_q;
	assign peak_min       = 16'(out_min_q);
	assign peak_max       = 16'(out_max_q);
	assign level_count    = out_count_q;
	assign levels_clipped = out_clip_q;
	assign last           = out_last_q;

	// top level never holds a pending peak
	assert property (@(posedge clk) disable iff (!arst_n)
		!pending_valid_q[MAX_LEVELS-1])
		else $error("pending peak at top level");

	// flush leaves no pending peaks before level counting
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COUNT) |-> (pending_valid_q == '0))
		else $error("pending peak left after flush");

	// a last sample always starts a flush
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && last_sample) |=> !in_ready)
		else $error("input taken during flush");

	// a summary beat always closes its sample's results
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q == KIND_SUMMARY) |-> out_last_q)
		else $error("summary beat without last");

endmodule
`default_nettype wire
